// ===== sv/nrfp_pkg.sv =====
// shared types and constants for the navigation result frame packer
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package nrfp_pkg;

  localparam int FrameBytes = 16;
  localparam int ByteIdxW   = $clog2(FrameBytes);
  localparam int ItemW      = 78;
  localparam int TdataInW   = ((ItemW + 7) / 8) * 8;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 10;
  localparam int MsW        = 10;

  localparam logic [ByteIdxW-1:0] LastByteIdx = ByteIdxW'(FrameBytes - 1);

  localparam logic [7:0]    HdrByte0    = 8'hA5;
  localparam logic [7:0]    HdrByte1    = 8'h5A;
  localparam logic [7:0]    VersionByte = 8'h01;
  localparam logic [7:0]    ConfMax     = 8'd100;
  localparam logic [7:0]    PointsMax   = 8'hFF;
  localparam logic [15:0]   BxInvalid   = 16'hFFFF;
  localparam logic [15:0]   BxMax       = 16'd65534;
  localparam logic [MsW-1:0] ElapsedMax    = 10'd1023;
  localparam logic [MsW-1:0] IntervalReset = 10'd100;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ENABLE   = 2'd0,
    CFG_INTERVAL = 2'd1
  } cfg_idx_e;

  typedef enum logic {
    ACT_TICK    = 1'b0,
    ACT_PUBLISH = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NO_LINE     = 2'd1,
    ST_PREDICT_ERR = 2'd2,
    ST_CAMERA_ERR  = 2'd3
  } nav_status_e;

  // msb first, so that the lowest tdata bits land in the last member
  typedef struct packed {
    logic signed [20:0] base_x;
    logic [11:0]        n_points;
    logic [8:0]         confidence;
    logic signed [16:0] angle;
    logic signed [15:0] deviation;
    logic               line_valid;
    logic [1:0]         status;
  } nav_item_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] seq;
    logic [15:0] dev;
    logic [15:0] ang;
    logic [7:0]  conf;
    logic [7:0]  pts;
    logic [15:0] bx;
    logic [1:0]  status;
  } frame_t;

  function automatic logic [15:0] sat_s16(logic signed [17:0] v);
    logic [15:0] r;
    if (v > 18'sd32767) begin
      r = 16'h7FFF;
    end else if (v < -18'sd32768) begin
      r = 16'h8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/nrfp_scale.sv =====
// fixed-point scaling, rounding and clamping of one navigation result
// depends on nrfp_pkg
`timescale 1ns / 1ps
`default_nettype none

module nrfp_scale import nrfp_pkg::*; (
  input  var nav_item_t   item_i,
  input  var logic [15:0] seq_i,
  output frame_t          frame_o
);

  logic              valid;
  logic signed [19:0] dev_p;
  logic [19:0]       dev_m;
  logic [19:0]       dev_sum;
  logic signed [17:0] dev_s;
  logic signed [23:0] ang_p;
  logic [23:0]       ang_m;
  logic [23:0]       ang_sum;
  logic signed [17:0] ang_s;
  logic [15:0]       conf_p;
  logic [16:0]       conf_sum;
  logic [8:0]        conf_r;
  logic [7:0]        conf_c;
  logic [7:0]        pts_c;
  logic [20:0]       bx_sum;
  logic [16:0]       bx_r;
  logic [15:0]       bx_c;

  assign valid = (item_i.status == ST_OK) && item_i.line_valid;

  // deviation x10, 4 fractional bits dropped with rounding away from zero
  assign dev_p   = $signed({{4{item_i.deviation[15]}}, item_i.deviation}) * 20'sd10;
  assign dev_m   = dev_p[19] ? 20'(-dev_p) : 20'(dev_p);
  assign dev_sum = dev_m + 20'd8;
  assign dev_s   = dev_p[19] ? -$signed({2'b00, dev_sum[19:4]})
                             :  $signed({2'b00, dev_sum[19:4]});

  // angle x100, 8 fractional bits
  assign ang_p   = $signed({{7{item_i.angle[16]}}, item_i.angle}) * 24'sd100;
  assign ang_m   = ang_p[23] ? 24'(-ang_p) : 24'(ang_p);
  assign ang_sum = ang_m + 24'd128;
  assign ang_s   = ang_p[23] ? -$signed({2'b00, ang_sum[23:8]})
                             :  $signed({2'b00, ang_sum[23:8]});

  // confidence x100, clamped to 100
  assign conf_p   = 16'(item_i.confidence) * 16'd100;
  assign conf_sum = {1'b0, conf_p} + 17'd128;
  assign conf_r   = conf_sum[16:8];
  assign conf_c   = (conf_r > 9'(ConfMax)) ? ConfMax : conf_r[7:0];

  assign pts_c = (|item_i.n_points[11:8]) ? PointsMax : item_i.n_points[7:0];

  // negative bottom x always clamps to zero
  assign bx_sum = {1'b0, item_i.base_x[19:0]} + 21'd8;
  assign bx_r   = bx_sum[20:4];
  always_comb begin
    if (item_i.base_x[20]) begin
      bx_c = 16'd0;
    end else if (bx_r > 17'(BxMax)) begin
      bx_c = BxMax;
    end else begin
      bx_c = bx_r[15:0];
    end
  end

  always_comb begin
    frame_o.valid  = valid;
    frame_o.seq    = seq_i;
    frame_o.status = item_i.status;
    if (valid) begin
      frame_o.dev  = sat_s16(dev_s);
      frame_o.ang  = sat_s16(ang_s);
      frame_o.conf = conf_c;
      frame_o.pts  = pts_c;
      frame_o.bx   = bx_c;
    end else begin
      frame_o.dev  = 16'd0;
      frame_o.ang  = 16'd0;
      frame_o.conf = 8'd0;
      frame_o.pts  = 8'd0;
      frame_o.bx   = BxInvalid;
    end
  end

endmodule

`default_nettype wire

// ===== sv/nrfp_serializer.sv =====
// frame register and byte serializer with running checksum
// depends on nrfp_pkg
`timescale 1ns / 1ps
`default_nettype none

module nrfp_serializer import nrfp_pkg::*; (
  input  var logic   clk_i,
  input  var logic   rst_ni,
  input  var logic   load_i,
  input  var frame_t frame_i,
  output logic       free_o,
  output logic       m_axis_tvalid_o,
  input  var logic   m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,
  output logic       m_axis_tlast_o
);

  frame_t              frame_q;
  logic                busy_q, busy_d;
  logic [ByteIdxW-1:0] cnt_q, cnt_d;
  logic [7:0]          sum_q, sum_d;
  logic [7:0]          byte_sel;
  logic                beat;
  logic                at_last;

  assign at_last = (cnt_q == LastByteIdx);
  assign beat    = busy_q && m_axis_tready_i;
  assign free_o  = !busy_q || (m_axis_tready_i && at_last);

  always_comb begin
    case (cnt_q)
      4'd0:    byte_sel = HdrByte0;
      4'd1:    byte_sel = HdrByte1;
      4'd2:    byte_sel = VersionByte;
      4'd3:    byte_sel = {7'd0, frame_q.valid};
      4'd4:    byte_sel = frame_q.seq[7:0];
      4'd5:    byte_sel = frame_q.seq[15:8];
      4'd6:    byte_sel = frame_q.dev[7:0];
      4'd7:    byte_sel = frame_q.dev[15:8];
      4'd8:    byte_sel = frame_q.ang[7:0];
      4'd9:    byte_sel = frame_q.ang[15:8];
      4'd10:   byte_sel = frame_q.conf;
      4'd11:   byte_sel = frame_q.pts;
      4'd12:   byte_sel = frame_q.bx[7:0];
      4'd13:   byte_sel = frame_q.bx[15:8];
      4'd14:   byte_sel = {6'd0, frame_q.status};
      default: byte_sel = sum_q;  // checksum of everything sent before
    endcase
  end

  assign m_axis_tvalid_o = busy_q;
  assign m_axis_tdata_o  = byte_sel;
  assign m_axis_tlast_o  = at_last;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    sum_d  = sum_q;
    if (load_i && free_o) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      sum_d  = 8'd0;
    end else if (beat) begin
      cnt_d = cnt_q + 1'b1;
      sum_d = sum_q + byte_sel;
      if (at_last) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      sum_q  <= 8'd0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      sum_q  <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && free_o) begin
      frame_q <= frame_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/nav_result_frame_packer.sv =====
// top level of the navigation result frame packer
// depends on nrfp_pkg, nrfp_scale and nrfp_serializer
`timescale 1ns / 1ps
`default_nettype none

// Turns navigation results into 16-byte little-endian frames, sent one byte per
// output beat with tlast on the checksum byte. Input beats carry tuser = action:
// 0 is a one millisecond tick, 1 publishes the result in tdata. A publish beat is
// framed only when enable is set and at least interval_ms ticks have passed since
// the last frame (the counter saturates at 1023, so the first publish after reset
// is always framed); otherwise it is dropped without any output. Each input beat
// is first captured in an input register; combinational scaling logic then loads
// the frame register, which the serializer walks through at one byte per cycle
// while tready is high. Ticks and dropped publishes keep flowing while a frame
// is being sent; a framed publish waits in the input register only until the
// last byte of the previous frame is accepted, so frames can follow back to
// back with tready held high downstream. Configuration writes go through a
// separate always-ready port: index 0 enable, index 1 interval_ms, other indexes
// ignored; write only while no frame is pending or in flight.
module nav_result_frame_packer import nrfp_pkg::*; (
  input  var logic                clk_i,
  input  var logic                rst_ni,
  // tdata: status[1:0], line_valid[2], deviation[18:3], angle[35:19],
  // confidence[44:36], n_points[56:45], base_x[77:57], zero pad
  input  var logic                s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  input  var logic [TdataInW-1:0] s_axis_tdata_i,
  input  var logic                s_axis_tuser_i,   // action
  // tdata: frame_byte[7:0]; tlast: last_byte
  output logic                    m_axis_tvalid_o,
  input  var logic                m_axis_tready_i,
  output logic [7:0]              m_axis_tdata_o,
  output logic                    m_axis_tlast_o,
  // configuration writes
  input  var logic                cfg_valid_i,
  output logic                    cfg_ready_o,
  input  var logic [CfgIdxW-1:0]  cfg_index_i,
  input  var logic [CfgDataW-1:0] cfg_data_i
);

  // configuration registers
  logic           enable_q;
  logic [MsW-1:0] interval_q;

  // rate limiter and sequence state
  logic [MsW-1:0] elapsed_q, elapsed_d;
  logic [15:0]    seq_q, seq_d;

  // input register
  logic      in_valid_q;
  action_e   in_act_q;
  nav_item_t in_item_q;

  logic   is_publish;
  logic   framed;
  logic   ser_free;
  logic   load;
  logic   consume;
  frame_t frame;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q   <= 1'b1;
      interval_q <= IntervalReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ENABLE:   enable_q   <= cfg_data_i[0];
        CFG_INTERVAL: interval_q <= cfg_data_i;
        default:      ;  // unknown index, write dropped
      endcase
    end
  end

  // publish is framed when enabled and the interval has run out
  assign is_publish = (in_act_q == ACT_PUBLISH);
  assign framed     = enable_q && (elapsed_q >= interval_q);
  // a framed publish needs the frame register, anything else retires now
  assign load       = in_valid_q && is_publish && framed && ser_free;
  assign consume    = in_valid_q && (!is_publish || !framed || ser_free);

  assign s_axis_tready_o = !in_valid_q || consume;

  always_comb begin
    elapsed_d = elapsed_q;
    seq_d     = seq_q;
    if (consume && !is_publish) begin
      if (elapsed_q != ElapsedMax) begin
        elapsed_d = elapsed_q + 1'b1;
      end
    end else if (load) begin
      elapsed_d = '0;
      seq_d     = seq_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q  <= ElapsedMax;
      seq_q      <= 16'd0;
      in_valid_q <= 1'b0;
    end else begin
      elapsed_q <= elapsed_d;
      seq_q     <= seq_d;
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
    end
  end

  // payload of the input register needs no reset
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_act_q  <= action_e'(s_axis_tuser_i);
      in_item_q <= nav_item_t'(s_axis_tdata_i[ItemW-1:0]);
    end
  end

  nrfp_scale u_scale (
    .item_i  (in_item_q),
    .seq_i   (seq_q),
    .frame_o (frame)
  );

  nrfp_serializer u_ser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (load),
    .frame_i         (frame),
    .free_o          (ser_free),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

`default_nettype wire

// ===== sv/nrfp_checker.sv =====
// port-level checks on the frame stream of the packer, bound to the top level
// depends on nrfp_pkg and nav_result_frame_packer
`timescale 1ns / 1ps
`default_nettype none

module nrfp_checker import nrfp_pkg::*; (
  input var logic       clk_i,
  input var logic       rst_ni,
  input var logic       m_axis_tvalid_o,
  input var logic       m_axis_tready_i,
  input var logic [7:0] m_axis_tdata_o,
  input var logic       m_axis_tlast_o
);

  logic [ByteIdxW-1:0] beat_cnt_q;
  logic [7:0]          sum_q;
  logic                out_beat;

  assign out_beat = m_axis_tvalid_o && m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_cnt_q <= '0;
      sum_q      <= 8'd0;
    end else if (out_beat) begin
      beat_cnt_q <= beat_cnt_q + 1'b1;
      sum_q      <= m_axis_tlast_o ? 8'd0 : sum_q + m_axis_tdata_o;
    end
  end

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output beat changed while stalled");

  // tlast lands on every sixteenth beat exactly
  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tlast_o == (beat_cnt_q == LastByteIdx)))
    else $error("tlast not on frame byte 15");

  // every frame opens with the sync header
  a_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (beat_cnt_q == '0) |-> (m_axis_tdata_o == HdrByte0))
    else $error("frame does not start with sync byte");

  // closing byte is the sum of the fifteen before it
  a_checksum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> (m_axis_tdata_o == sum_q))
    else $error("frame checksum mismatch");

endmodule

bind nav_result_frame_packer nrfp_checker u_nrfp_checker (.*);

`default_nettype wire

// ===== tb/nrfp_frame_checker.sv =====
// frame checker for the navigation result frame packer testbench
// depends on nrfp_pkg; watches the config, input and output channels of the block
`timescale 1ns / 1ps

module nrfp_frame_checker import nrfp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  input  logic                s_tready_i,
  input  logic [TdataInW-1:0] s_tdata_i,
  input  logic                s_tuser_i,
  input  logic                m_tvalid_i,
  input  logic                m_tready_i,
  input  logic [7:0]          m_tdata_i,
  input  logic                m_tlast_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int                  errors_o,
  output int                  pending_o,
  output int                  frames_o,
  output int                  dropped_o
);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_beat_t;

  frame_beat_t    frame_beat_q[$];
  frame_beat_t    want_beat;
  nav_item_t      in_item;
  logic           enable_r;
  logic [MsW-1:0] interval_r;
  logic [MsW-1:0] elapsed_r;
  logic [15:0]    seq_r;
  int             err_cnt;
  int             frame_cnt;
  int             drop_cnt;

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    err_cnt++;
  endtask

  // divide by 2^sh, rounding half away from zero
  function automatic longint round_half_away(longint v, int unsigned sh);
    longint mag;
    mag = (v < 0) ? -v : v;
    mag = (mag + (longint'(1) << (sh - 1))) >> sh;
    return (v < 0) ? -mag : mag;
  endfunction

  function automatic longint clamp_to(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // builds the 16 frame bytes of one published result and queues them
  function automatic void pack_nav_frame(nav_item_t it);
    logic [7:0]  fb [FrameBytes];
    logic        line_ok;
    logic [15:0] dev_w, ang_w, bx_w;
    logic [7:0]  sum;
    longint      dev, ang, conf, pts, bx;
    frame_beat_t nb;
    line_ok = (nav_status_e'(it.status) == ST_OK) && it.line_valid;
    for (int i = 0; i < FrameBytes; i++) fb[i] = 8'h00;
    fb[0] = HdrByte0;
    fb[1] = HdrByte1;
    fb[2] = VersionByte;
    fb[3] = {7'd0, line_ok};
    fb[4] = seq_r[7:0];
    fb[5] = seq_r[15:8];
    seq_r = seq_r + 16'd1;
    if (line_ok) begin
      dev  = clamp_to(round_half_away(longint'($signed(it.deviation)) * 10, 4), -32768, 32767);
      ang  = clamp_to(round_half_away(longint'($signed(it.angle)) * 100, 8), -32768, 32767);
      conf = clamp_to(round_half_away(longint'(it.confidence) * 100, 8), 0, ConfMax);
      pts  = clamp_to(longint'(it.n_points), 0, PointsMax);
      bx   = clamp_to(round_half_away(longint'($signed(it.base_x)), 4), 0, BxMax);
      dev_w = dev[15:0];
      ang_w = ang[15:0];
      bx_w  = bx[15:0];
      fb[6]  = dev_w[7:0];
      fb[7]  = dev_w[15:8];
      fb[8]  = ang_w[7:0];
      fb[9]  = ang_w[15:8];
      fb[10] = conf[7:0];
      fb[11] = pts[7:0];
      fb[12] = bx_w[7:0];
      fb[13] = bx_w[15:8];
    end else begin
      // no usable line: measurements stay zero, bottom x marked invalid
      fb[12] = BxInvalid[7:0];
      fb[13] = BxInvalid[15:8];
    end
    fb[14] = {6'd0, it.status};
    sum = 8'h00;
    for (int i = 0; i < FrameBytes - 1; i++) sum = sum + fb[i];
    fb[FrameBytes-1] = sum;
    for (int i = 0; i < FrameBytes; i++) begin
      nb.data = fb[i];
      nb.last = (i == FrameBytes - 1);
      frame_beat_q.insert(frame_beat_q.size(), nb);
    end
    frame_cnt++;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_r   = 1'b1;
      interval_r = IntervalReset;
      elapsed_r  = ElapsedMax;
      seq_r      = '0;
      frame_beat_q.delete();
      err_cnt    = 0;
      frame_cnt  = 0;
      drop_cnt   = 0;
      errors_o  <= 0;
      pending_o <= 0;
      frames_o  <= 0;
      dropped_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_ENABLE:   enable_r = cfg_data_i[0];
          CFG_INTERVAL: interval_r = cfg_data_i;
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) begin
        in_item = nav_item_t'(s_tdata_i[ItemW-1:0]);
        if (action_e'(s_tuser_i) == ACT_TICK) begin
          if (elapsed_r != ElapsedMax) elapsed_r = elapsed_r + 1'b1;
        end else if (!enable_r || elapsed_r < interval_r) begin
          drop_cnt++;
        end else begin
          elapsed_r = '0;
          pack_nav_frame(in_item);
        end
      end
      if (m_tvalid_i && m_tready_i) begin
        if (frame_beat_q.size() == 0) begin
          report_mismatch("beat with no frame pending", m_tdata_i, 0);
        end else begin
          want_beat = frame_beat_q[0];
          frame_beat_q.delete(0);
          if (m_tdata_i !== want_beat.data) begin
            report_mismatch("frame_byte", m_tdata_i, want_beat.data);
          end
          if (m_tlast_i !== want_beat.last) begin
            report_mismatch("last_byte", m_tlast_i, want_beat.last);
          end
        end
      end
      errors_o  <= err_cnt;
      pending_o <= frame_beat_q.size();
      frames_o  <= frame_cnt;
      dropped_o <= drop_cnt;
    end
  end

endmodule

// ===== tb/nav_result_frame_packer_tb.sv =====
// testbench top for the navigation result frame packer
// depends on nrfp_pkg, nrfp_frame_checker and the block itself
`timescale 1ns / 1ps

module nav_result_frame_packer_tb;
  import nrfp_pkg::*;

  localparam int ClkHalf      = 6;
  localparam int ResetCycles  = 3;
  localparam int SettleCycles = 24;   // input register, scaling stage, serializer
  localparam int IdleLimit    = 2000; // cycles without any beat before giving up

  // config indexes the block must ignore
  localparam logic [CfgIdxW-1:0] CfgIdxSpareLo = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgIdxSpareHi = 2'd3;

  // downstream stall patterns
  localparam int RxFree     = 0;
  localparam int RxRandom   = 1;
  localparam int RxPeriodic = 2;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_tvalid = 1'b0;
  logic [TdataInW-1:0] s_tdata = '0;
  logic                s_tuser = 1'b0;
  logic                m_tready = 1'b1;
  logic                cfg_valid = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  logic                s_tready_o;
  logic                m_tvalid_o;
  logic [7:0]          m_tdata_o;
  logic                m_tlast_o;
  logic                cfg_ready_o;

  int chk_errors, chk_pending, chk_frames, chk_dropped;
  int burst_left = 0;
  int ticks_sent = 0;
  int pubs_sent  = 0;
  int idle_cycles = 0;
  int rx_mode = RxFree;
  int rx_left = 0;
  int cyc = 0;

  nav_result_frame_packer u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata_o),
    .m_axis_tlast_o  (m_tlast_o),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  nrfp_frame_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_tvalid),
    .s_tready_i  (s_tready_o),
    .s_tdata_i   (s_tdata),
    .s_tuser_i   (s_tuser),
    .m_tvalid_i  (m_tvalid_o),
    .m_tready_i  (m_tready),
    .m_tdata_i   (m_tdata_o),
    .m_tlast_i   (m_tlast_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .errors_o    (chk_errors),
    .pending_o   (chk_pending),
    .frames_o    (chk_frames),
    .dropped_o   (chk_dropped)
  );

  initial begin
    forever #ClkHalf clk_i = ~clk_i;
  end

  // downstream ready: switches at random between free flow, random stalls and a
  // fixed stall rhythm
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(RxFree, RxPeriodic);
      rx_left <= $urandom_range(20, 120);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RxFree:   m_tready <= 1'b1;
      RxRandom: m_tready <= ($urandom_range(0, 3) != 0);
      default:  m_tready <= ((cyc % 5) < 2);
    endcase
  end

  // watchdog: any accepted beat on any channel counts as progress
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_tvalid && s_tready_o) || (m_tvalid_o && m_tready) ||
          (cfg_valid && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("watchdog: no beat for %0d cycles, %0d bytes outstanding",
                 idle_cycles, chk_pending);
        $display("FAILED: results differ");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic nav_item_t make_item(nav_status_e st, bit lv, int dev, int ang,
                                          int conf, int pts, int bx);
    nav_item_t it;
    it.status     = st;
    it.line_valid = lv;
    it.deviation  = 16'(dev);
    it.angle      = 17'(ang);
    it.confidence = 9'(conf);
    it.n_points   = 12'(pts);
    it.base_x     = 21'(bx);
    return it;
  endfunction

  // mostly good lines so the scaling path is exercised, extremes now and then
  function automatic nav_item_t rand_nav_item();
    nav_item_t it;
    it.status     = ($urandom_range(0, 3) != 0) ? ST_OK : nav_status_e'($urandom_range(0, 3));
    it.line_valid = ($urandom_range(0, 7) != 0);
    case ($urandom_range(0, 7))
      0:       it.deviation = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      1:       it.deviation = 16'($signed($urandom_range(0, 128)) - 64);
      default: it.deviation = 16'($urandom);
    endcase
    case ($urandom_range(0, 7))
      0:       it.angle = $urandom_range(0, 1) ? 17'sh0FFFF : 17'sh10000;
      1:       it.angle = 17'($signed($urandom_range(0, 128)) - 64);
      default: it.angle = 17'($urandom);
    endcase
    it.confidence = $urandom_range(0, 3) ? 9'($urandom_range(0, 511))
                                         : 9'($urandom_range(250, 262));
    it.n_points   = $urandom_range(0, 1) ? 12'($urandom_range(0, 300))
                                         : 12'($urandom_range(0, 4095));
    if ($urandom_range(0, 3) == 0) begin
      it.base_x = 21'(-$signed($urandom_range(1, 65536)));
    end else begin
      it.base_x = 21'($urandom_range(0, 1048575));
    end
    return it;
  endfunction

  // one input beat; bursts of random length separated by random gaps
  task automatic send_beat(action_e act, nav_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      case ($urandom_range(0, 5))
        0, 1:    gap = 0;
        5:       gap = $urandom_range(8, 20);
        default: gap = $urandom_range(1, 5);
      endcase
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= TdataInW'(it);
    s_tuser  <= act;
    do @(posedge clk_i); while (!s_tready_o);
    if (act == ACT_TICK) ticks_sent++;
    else pubs_sent++;
  endtask

  // hold off the sender until every predicted byte is out and the pipe is empty
  task automatic drain();
    s_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (chk_pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_beat(ACT_TICK, rand_nav_item());
  endtask

  // well-formed pacing: about interval ticks, then a publish, some noise
  task automatic run_paced(int frames, int ivl);
    int n_ticks;
    repeat (frames) begin
      n_ticks = ivl + $urandom_range(0, 1);
      if ($urandom_range(0, 7) == 0 && n_ticks > 0) n_ticks--;
      send_ticks(n_ticks);
      send_beat(ACT_PUBLISH, rand_nav_item());
      if ($urandom_range(0, 5) == 0) send_beat(ACT_PUBLISH, rand_nav_item());
    end
  endtask

  task automatic run_mixed(int n, int pub_pct);
    repeat (n) begin
      if ($urandom_range(0, 99) < pub_pct) send_beat(ACT_PUBLISH, rand_nav_item());
      else send_beat(ACT_TICK, rand_nav_item());
    end
  endtask

  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // counter comes out of reset saturated: ticks must hold it there, so a
    // publish passes even with the interval at its top value
    write_reg(CFG_INTERVAL, 10'd1023);
    send_ticks(2);
    send_beat(ACT_PUBLISH, make_item(ST_OK, 1'b1, 320, 2560, 128, 40, 5120));
    send_beat(ACT_PUBLISH, rand_nav_item());   // counter just cleared: held back
    drain();

    // interval zero: every enabled publish is framed
    write_reg(CFG_INTERVAL, 10'd0);
    // saturation and clamping at the top of every field
    send_beat(ACT_PUBLISH, make_item(ST_OK, 1'b1, 32767, 65535, 511, 4095, 1048575));
    // bottom of every field
    send_beat(ACT_PUBLISH, make_item(ST_OK, 1'b1, -32768, -65536, 0, 0, -65536));
    // exact halves round away from zero
    send_beat(ACT_PUBLISH, make_item(ST_OK, 1'b1, 4, 32, 255, 255, 8));
    send_beat(ACT_PUBLISH, make_item(ST_OK, 1'b1, -4, -32, 256, 256, 1048552));
    send_beat(ACT_PUBLISH, make_item(ST_OK, 1'b1, 1, 1, 1, 1, -8));
    send_beat(ACT_PUBLISH, make_item(ST_OK, 1'b1, -1, -1, 2, 254, 1048544));
    // no usable line: measurements zeroed, status still sent
    send_beat(ACT_PUBLISH, make_item(ST_OK, 1'b0, 1000, 1000, 200, 100, 4000));
    send_beat(ACT_PUBLISH, make_item(ST_NO_LINE, 1'b1, 1000, 1000, 200, 100, 4000));
    send_beat(ACT_PUBLISH, make_item(ST_PREDICT_ERR, 1'b1, -777, 999, 300, 9, 16));
    send_beat(ACT_PUBLISH, make_item(ST_CAMERA_ERR, 1'b0, 32767, -65536, 511, 4095, -1));
    drain();

    // disabled: publishes held back; only bit 0 of the write counts
    write_reg(CFG_ENABLE, 10'h3FE);
    send_beat(ACT_PUBLISH, rand_nav_item());
    send_beat(ACT_TICK, rand_nav_item());
    drain();
    write_reg(CFG_ENABLE, 10'h001);
    // writes to unused indexes must change nothing
    write_reg(CfgIdxSpareLo, 10'h000);
    write_reg(CfgIdxSpareHi, 10'h3FE);
    send_beat(ACT_PUBLISH, rand_nav_item());
    drain();

    // random part over several intervals
    write_reg(CFG_INTERVAL, 10'd1);
    run_paced(20, 1);
    drain();
    write_reg(CFG_INTERVAL, 10'd0);
    run_mixed(40, 70);
    drain();
    write_reg(CFG_INTERVAL, 10'd3);
    run_paced(15, 3);
    drain();
    write_reg(CFG_ENABLE, 10'h000);
    run_mixed(20, 50);
    drain();
    write_reg(CFG_ENABLE, 10'h001);
    write_reg(CFG_INTERVAL, 10'd2);
    run_mixed(40, 40);
    drain();

    // a longer interval, hit exactly at the boundary
    write_reg(CFG_INTERVAL, 10'd0);
    send_beat(ACT_PUBLISH, rand_nav_item());   // clears the counter
    drain();
    write_reg(CFG_INTERVAL, 10'd30);
    send_ticks(29);
    send_beat(ACT_PUBLISH, rand_nav_item());   // one short: held back
    send_ticks(1);
    send_beat(ACT_PUBLISH, rand_nav_item());
    drain();

    $display("stimulus: %0d ticks, %0d publishes; %0d frames checked, %0d publishes held back",
             ticks_sent, pubs_sent, chk_frames, chk_dropped);
    $display("intervals 1023, 0, 1, 3, 2 and 30, enable cleared and set, spare indexes written");
    if (chk_errors == 0 && chk_pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
